// ===== rtl/ccdc_pkg.sv =====
package ccdc_pkg;

  // Bytes per captured field; the DMA offset counter spans one field
  localparam int FIELD_BYTES = 128;
  localparam int OFFSET_W    = $clog2(FIELD_BYTES);
  localparam int ADDR_W      = 16;
  localparam int PAGE_W      = ADDR_W - OFFSET_W;

  // Depth of the queue between the front and back parts
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Bus and camera commands
  typedef enum logic [2:0] {
    CMD_WRITE_A = 3'd0,
    CMD_WRITE_B = 3'd1,
    CMD_WRITE_C = 3'd2,
    CMD_READ_A  = 3'd3,
    CMD_CAM_BYTE = 3'd4,
    CMD_MS_TICK = 3'd5
  } cmd_t;

  // Result kinds
  typedef enum logic [1:0] {
    KIND_READ = 2'd0,
    KIND_CAM_CMD = 2'd1,
    KIND_DMA = 2'd2
  } kind_t;

  // One pending result: address parts are zero for non-DMA kinds
  typedef struct packed {
    kind_t               kind;
    logic [7:0]          value;
    logic [7:0]          base_page;
    logic [3:0]          field_index;
    logic [OFFSET_W-1:0] byte_offset;
  } desc_t;

endpackage

// ===== rtl/camera_capture_dma_controller_core.sv =====
// A result is written into the result queue when its input transfer is accepted;
// it is then moved from the queue head into the output register that drives the out_ channel once that is free.
// Throughput: one input transfer per cycle; the four-entry result queue stalls
// in_ready only when it is full behind a stalled output.
// Reset (rst_n low, synchronous): clears all flag, format, capture and counter state,
// empties the queue and drops the output valid.
module camera_capture_dma_controller_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  in_cmd,
  input  logic [7:0]  in_data,
  input  logic        in_camera_present,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_kind,
  output logic [7:0]  out_value,
  output logic [15:0] out_dma_address
);
  import ccdc_pkg::*;

  logic  accept;
  logic  push;
  desc_t push_desc;
  logic  pop;
  logic  full;
  logic  head_valid;
  desc_t head_desc;

  assign in_ready = !full;
  assign accept   = in_valid && in_ready;

  ccdc_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .accept         (accept),
    .cmd            (in_cmd),
    .data           (in_data),
    .camera_present (in_camera_present),
    .push           (push),
    .push_desc      (push_desc)
  );

  ccdc_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_desc  (push_desc),
    .pop        (pop),
    .full       (full),
    .head_valid (head_valid),
    .head_desc  (head_desc)
  );

  ccdc_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .head_valid      (head_valid),
    .head_desc       (head_desc),
    .pop             (pop),
    .out_ready       (out_ready),
    .out_valid       (out_valid),
    .out_kind        (out_kind),
    .out_value       (out_value),
    .out_dma_address (out_dma_address)
  );

  // Never push into a full queue
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !full)
    else $error("result pushed into full queue");

  // Never pop an empty queue
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> head_valid)
    else $error("result popped from empty queue");

  // Only DMA results carry an address
  a_addr_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_kind != KIND_DMA) |-> (out_dma_address == 16'd0))
    else $error("non-DMA result with nonzero address");

endmodule

// ===== rtl/ccdc_front.sv =====
module ccdc_front (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           accept,
  input  logic [2:0]     cmd,
  input  logic [7:0]     data,
  input  logic           camera_present,
  output logic           push,
  output ccdc_pkg::desc_t push_desc
);
  import ccdc_pkg::*;

  logic [6:0]          flag_bits_r, flag_bits_nxt;
  logic [7:0]          format_r, format_nxt;
  logic [7:0]          base_page_r, base_page_nxt;
  logic                busy_r, busy_nxt;
  logic                receiving_r, receiving_nxt;
  logic [3:0]          field_r, field_nxt;
  logic [OFFSET_W-1:0] offset_r, offset_nxt;
  logic [6:0]          elapsed_r, elapsed_nxt;

  logic [3:0] field_count;
  logic [5:0] frame_units;
  logic [6:0] frame_time;
  logic [3:0] field_inc;

  // Frame time: fields * (interval + 1) * 2, at most 120
  assign field_count = format_r[3:0];
  assign frame_units = 6'(field_count) * (6'(format_r[5:4]) + 6'd1);
  assign frame_time  = {frame_units, 1'b0};
  assign field_inc   = field_r + 4'd1;

  // Classify the transfer and update the capture state
  always_comb begin
    flag_bits_nxt = flag_bits_r;
    format_nxt    = format_r;
    base_page_nxt = base_page_r;
    busy_nxt      = busy_r;
    receiving_nxt = receiving_r;
    field_nxt     = field_r;
    offset_nxt    = offset_r;
    elapsed_nxt   = elapsed_r;
    push          = 1'b0;
    push_desc     = '{kind: KIND_READ, value: 8'd0, base_page: 8'd0,
                      field_index: 4'd0, byte_offset: '0};
    if (accept) begin
      case (cmd_t'(cmd))
        CMD_WRITE_A: begin
          flag_bits_nxt = data[6:0];
          if (data[7] && camera_present) begin
            if (!busy_r) begin
              busy_nxt        = 1'b1;
              receiving_nxt   = (field_count != 4'd0);
              field_nxt       = 4'd0;
              offset_nxt      = '0;
              elapsed_nxt     = 7'd0;
              push            = 1'b1;
              push_desc.kind  = KIND_CAM_CMD;
              push_desc.value = format_r | {1'b0, data[5], 6'd0};
            end
          end else begin
            busy_nxt      = 1'b0;
            receiving_nxt = 1'b0;
          end
        end
        CMD_WRITE_B: format_nxt = data;
        CMD_WRITE_C: base_page_nxt = data;
        CMD_READ_A: begin
          push            = 1'b1;
          push_desc.kind  = KIND_READ;
          push_desc.value = {busy_r, flag_bits_r};
        end
        CMD_CAM_BYTE: begin
          if (receiving_r) begin
            if (field_r >= field_count) begin
              receiving_nxt = 1'b0;
            end else begin
              push                  = 1'b1;
              push_desc.kind        = KIND_DMA;
              push_desc.value       = data;
              push_desc.base_page   = base_page_r;
              push_desc.field_index = field_r;
              push_desc.byte_offset = offset_r;
              if (&offset_r) begin
                offset_nxt = '0;
                field_nxt  = field_inc;
                if (field_inc == 4'd0 || field_inc >= field_count) begin
                  receiving_nxt = 1'b0;
                end
              end else begin
                offset_nxt = offset_r + 1'b1;
              end
            end
          end
        end
        CMD_MS_TICK: begin
          if (busy_r) begin
            elapsed_nxt = (elapsed_r == 7'd127) ? elapsed_r : elapsed_r + 7'd1;
            if (!receiving_r && elapsed_nxt >= frame_time) begin
              busy_nxt = 1'b0;
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flag_bits_r <= '0;
      format_r    <= '0;
      base_page_r <= '0;
      busy_r      <= 1'b0;
      receiving_r <= 1'b0;
      field_r     <= '0;
      offset_r    <= '0;
      elapsed_r   <= '0;
    end else begin
      flag_bits_r <= flag_bits_nxt;
      format_r    <= format_nxt;
      base_page_r <= base_page_nxt;
      busy_r      <= busy_nxt;
      receiving_r <= receiving_nxt;
      field_r     <= field_nxt;
      offset_r    <= offset_nxt;
      elapsed_r   <= elapsed_nxt;
    end
  end

endmodule

// ===== rtl/ccdc_queue.sv =====
module ccdc_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  ccdc_pkg::desc_t push_desc,
  input  logic            pop,
  output logic            full,
  output logic            head_valid,
  output ccdc_pkg::desc_t head_desc
);
  import ccdc_pkg::*;

  desc_t             mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] count_r, count_nxt;

  assign full       = (count_r == QCNT_W'(QUEUE_DEPTH));
  assign head_valid = (count_r != '0);
  assign head_desc  = mem[rd_ptr_r];

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r + QCNT_W'(push) - QCNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Store pending results
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_desc;
    end
  end

endmodule

// ===== rtl/ccdc_back.sv =====
module ccdc_back (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            head_valid,
  input  ccdc_pkg::desc_t head_desc,
  output logic            pop,
  input  logic            out_ready,
  output logic            out_valid,
  output logic [1:0]      out_kind,
  output logic [7:0]      out_value,
  output logic [15:0]     out_dma_address
);
  import ccdc_pkg::*;

  logic                out_valid_r, out_valid_nxt;
  logic [1:0]          kind_r;
  logic [7:0]          value_r;
  logic [ADDR_W-1:0]   addr_r;
  logic [PAGE_W-1:0]   page_sum;

  // Page of the DMA address: base page plus field, modulo the address space
  assign page_sum = PAGE_W'(head_desc.base_page) + PAGE_W'(head_desc.field_index);

  assign pop = head_valid && (!out_valid_r || out_ready);

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (pop) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  // Load the output register from the queue head
  always_ff @(posedge clk) begin
    if (pop) begin
      kind_r  <= head_desc.kind;
      value_r <= head_desc.value;
      addr_r  <= {page_sum, head_desc.byte_offset};
    end
  end

  assign out_valid       = out_valid_r;
  assign out_kind        = kind_r;
  assign out_value       = value_r;
  assign out_dma_address = addr_r;

endmodule
